@@ src/cte_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the text buffer editor.
package cte_pkg;

	// Node pool: index zero is the head, the rest hold characters.
	localparam int CAPACITY   = 255;
	localparam int POOL_DEPTH = CAPACITY + 1;
	localparam int NODE_W     = $clog2(POOL_DEPTH);
	localparam int FREE_W     = $clog2(CAPACITY);
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int FRESH_W    = NODE_W + 1;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 8;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_LEFT   = 3'd2,
		OP_RIGHT  = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Work step that the controller asks the datapath to perform.
	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_EXEC,
		STEP_LINK,
		STEP_FETCH,
		STEP_FIN
	} step_t;

	typedef struct packed {
		step_t step;
		logic  capture;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic go_link;
		logic go_fetch;
	} sts_t;

endpackage

@@ src/cte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/cte_ctrl.sv @@
// Controller state machine that sequences each request through the datapath steps.
module cte_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output logic          m_valid,
	input  logic          m_ready,
	output cte_pkg::cmd_t cmd,
	input  cte_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_FETCH,
		S_FIN
	} state_t;

	state_t state_q;
	logic   m_valid_q;
	logic   out_free;

	assign out_free = !m_valid_q || m_ready;
	assign s_ready  = (state_q == S_IDLE);
	assign m_valid  = m_valid_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd.capture  = (state_q == S_IDLE) && s_valid;
		cmd.load_out = (state_q == S_FIN) && out_free;
		unique case (state_q)
			S_IDLE:  cmd.step = cte_pkg::STEP_IDLE;
			S_EXEC:  cmd.step = cte_pkg::STEP_EXEC;
			S_LINK:  cmd.step = cte_pkg::STEP_LINK;
			S_FETCH: cmd.step = cte_pkg::STEP_FETCH;
			S_FIN:   cmd.step = cte_pkg::STEP_FIN;
			default: cmd.step = cte_pkg::STEP_IDLE;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			// In the final state a taken result is replaced by the new one below.
			if (m_valid_q && m_ready && (state_q != S_FIN)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (sts.go_link) begin
						state_q <= S_LINK;
					end else if (sts.go_fetch) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LINK:  state_q <= S_FIN;
				S_FETCH: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/cte_dp.sv @@
// Datapath: node pool memories, list pointers, counters and the result register.
module cte_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cte_pkg::cmd_t                cmd,
	output cte_pkg::sts_t                sts,
	input  logic [2:0]                   in_opcode,
	input  logic [cte_pkg::CHAR_W-1:0]   in_char,
	output logic [1:0]                   out_status,
	output logic [cte_pkg::CHAR_W-1:0]   out_char,
	output logic                         out_last,
	output logic [cte_pkg::LEN_W-1:0]    out_length
);

	localparam int NW = cte_pkg::NODE_W;
	localparam int FW = cte_pkg::FREE_W;
	localparam int CW = cte_pkg::COUNT_W;

	// List state.
	logic [NW-1:0]                cursor_q;
	logic [NW-1:0]                read_q;
	logic [cte_pkg::FRESH_W-1:0]  fresh_q;
	logic [CW-1:0]                free_cnt_q;
	logic [CW-1:0]                count_q;
	logic [NW-1:0]                head_next_q;

	// Per-request working registers.
	cte_pkg::opcode_t             op_q;
	logic [cte_pkg::CHAR_W-1:0]   char_q;
	logic [NW-1:0]                node_q;
	logic [NW-1:0]                after_q;
	logic                         nrd_zero_q;
	cte_pkg::status_t             res_status_q;
	logic [cte_pkg::CHAR_W-1:0]   res_char_q;
	logic                         res_last_q;

	// Memory ports.
	logic                         next_we, prev_we, char_we, free_we;
	logic [NW-1:0]                next_waddr, next_wdata, next_raddr, next_rdata;
	logic [NW-1:0]                prev_waddr, prev_wdata, prev_raddr, prev_rdata;
	logic [NW-1:0]                char_waddr, char_raddr;
	logic [cte_pkg::CHAR_W-1:0]   char_wdata, char_rdata;
	logic [FW-1:0]                free_waddr, free_raddr;
	logic [NW-1:0]                free_wdata, free_rdata;

	// Derived values.
	logic [NW-1:0]                nxt_v;
	logic [NW-1:0]                node_new;
	logic [NW-1:0]                rd_node;
	logic                         refuse_ins;
	logic                         read_empty;
	logic                         free_room;
	cte_pkg::status_t             ex_status;

	cte_ram #(.WIDTH(NW), .DEPTH(cte_pkg::POOL_DEPTH)) u_next_mem (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
		.raddr(next_raddr), .rdata(next_rdata)
	);

	cte_ram #(.WIDTH(NW), .DEPTH(cte_pkg::POOL_DEPTH)) u_prev_mem (
		.clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
		.raddr(prev_raddr), .rdata(prev_rdata)
	);

	cte_ram #(.WIDTH(cte_pkg::CHAR_W), .DEPTH(cte_pkg::POOL_DEPTH)) u_char_mem (
		.clk(clk), .we(char_we), .waddr(char_waddr), .wdata(char_wdata),
		.raddr(char_raddr), .rdata(char_rdata)
	);

	cte_ram #(.WIDTH(NW), .DEPTH(cte_pkg::CAPACITY)) u_free_mem (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rdata)
	);

	// The head's successor lives in a register so that it is valid from reset.
	assign nxt_v      = nrd_zero_q ? head_next_q : next_rdata;
	assign node_new   = (free_cnt_q != '0) ? free_rdata : fresh_q[NW-1:0];
	assign rd_node    = (nxt_v != '0) ? nxt_v : head_next_q;
	assign refuse_ins = (count_q >= CW'(cte_pkg::CAPACITY)) ||
		((free_cnt_q == '0) && (fresh_q > cte_pkg::FRESH_W'(cte_pkg::CAPACITY)));
	assign read_empty = (count_q == '0) || (head_next_q == '0);
	assign free_room  = free_cnt_q < CW'(cte_pkg::CAPACITY);

	assign sts.go_link  = (op_q == cte_pkg::OP_INSERT) && !refuse_ins;
	assign sts.go_fetch = (op_q == cte_pkg::OP_READ) && !read_empty;

	// Read addresses: the idle cycle prefetches the links around the cursor or read pointer.
	always_comb begin
		prev_raddr = cursor_q;
		char_raddr = rd_node;
		free_raddr = (free_cnt_q == '0) ? '0 : FW'(free_cnt_q - 1'b1);
		unique case (cmd.step)
			cte_pkg::STEP_IDLE:
				next_raddr = (in_opcode == cte_pkg::OP_READ) ? read_q : cursor_q;
			cte_pkg::STEP_EXEC:
				next_raddr = rd_node;
			default:
				next_raddr = cursor_q;
		endcase
	end

	// Outcome of the execute step and the memory writes of each step.
	always_comb begin
		ex_status  = cte_pkg::ST_IGNORED;
		next_we    = 1'b0;
		next_waddr = '0;
		next_wdata = '0;
		prev_we    = 1'b0;
		prev_waddr = '0;
		prev_wdata = '0;
		char_we    = 1'b0;
		char_waddr = node_new;
		char_wdata = char_q;
		free_we    = 1'b0;
		free_waddr = FW'(free_cnt_q);
		free_wdata = cursor_q;
		unique case (cmd.step)
			cte_pkg::STEP_EXEC: begin
				unique case (op_q)
					cte_pkg::OP_INSERT: begin
						if (refuse_ins) begin
							ex_status = cte_pkg::ST_FULL;
						end else begin
							ex_status  = cte_pkg::ST_DONE;
							char_we    = 1'b1;
							next_we    = 1'b1;
							next_waddr = node_new;
							next_wdata = nxt_v;
							prev_we    = 1'b1;
							prev_waddr = node_new;
							prev_wdata = cursor_q;
						end
					end
					cte_pkg::OP_DELETE: begin
						if (cursor_q != '0) begin
							ex_status  = cte_pkg::ST_DONE;
							next_we    = 1'b1;
							next_waddr = prev_rdata;
							next_wdata = nxt_v;
							prev_we    = (nxt_v != '0);
							prev_waddr = nxt_v;
							prev_wdata = prev_rdata;
							free_we    = free_room;
						end
					end
					cte_pkg::OP_LEFT: begin
						if (cursor_q != '0) begin
							ex_status = cte_pkg::ST_DONE;
						end
					end
					cte_pkg::OP_RIGHT: begin
						if (nxt_v != '0) begin
							ex_status = cte_pkg::ST_DONE;
						end
					end
					cte_pkg::OP_READ: begin
						ex_status = read_empty ? cte_pkg::ST_EMPTY : cte_pkg::ST_DONE;
					end
					default: ex_status = cte_pkg::ST_IGNORED;
				endcase
			end
			cte_pkg::STEP_LINK: begin
				next_we    = 1'b1;
				next_waddr = cursor_q;
				next_wdata = node_q;
				prev_we    = (after_q != '0);
				prev_waddr = after_q;
				prev_wdata = node_q;
			end
			default: ;
		endcase
	end

	// List pointers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			read_q      <= '0;
			fresh_q     <= cte_pkg::FRESH_W'(1);
			free_cnt_q  <= '0;
			count_q     <= '0;
			head_next_q <= '0;
		end else begin
			if (next_we && (next_waddr == '0)) begin
				head_next_q <= next_wdata;
			end
			unique case (cmd.step)
				cte_pkg::STEP_EXEC: begin
					unique case (op_q)
						cte_pkg::OP_INSERT: begin
							if (!refuse_ins) begin
								if (free_cnt_q != '0) begin
									free_cnt_q <= free_cnt_q - 1'b1;
								end else begin
									fresh_q <= fresh_q + 1'b1;
								end
							end
						end
						cte_pkg::OP_DELETE: begin
							if (cursor_q != '0) begin
								if (read_q == cursor_q) begin
									read_q <= prev_rdata;
								end
								if (free_room) begin
									free_cnt_q <= free_cnt_q + 1'b1;
								end
								if (count_q != '0) begin
									count_q <= count_q - 1'b1;
								end
								cursor_q <= prev_rdata;
							end
						end
						cte_pkg::OP_LEFT: begin
							if (cursor_q != '0) begin
								cursor_q <= prev_rdata;
							end
						end
						cte_pkg::OP_RIGHT: begin
							if (nxt_v != '0) begin
								cursor_q <= nxt_v;
							end
						end
						default: ;
					endcase
				end
				cte_pkg::STEP_LINK: begin
					cursor_q <= node_q;
					count_q  <= count_q + 1'b1;
				end
				cte_pkg::STEP_FETCH: begin
					read_q <= (nxt_v == '0) ? '0 : node_q;
				end
				default: ;
			endcase
		end
	end

	// Request capture, working registers and the output register.
	always_ff @(posedge clk) begin
		nrd_zero_q <= (next_raddr == '0);
		if (cmd.capture) begin
			op_q   <= cte_pkg::opcode_t'(in_opcode);
			char_q <= in_char;
		end
		if (cmd.step == cte_pkg::STEP_EXEC) begin
			node_q       <= (op_q == cte_pkg::OP_READ) ? rd_node : node_new;
			after_q      <= nxt_v;
			res_status_q <= ex_status;
			res_char_q   <= '0;
			res_last_q   <= 1'b0;
		end
		if (cmd.step == cte_pkg::STEP_FETCH) begin
			res_char_q <= char_rdata;
			res_last_q <= (nxt_v == '0);
		end
		if (cmd.load_out) begin
			out_status <= res_status_q;
			out_char   <= res_char_q;
			out_last   <= res_last_q;
			out_length <= cte_pkg::LEN_W'(count_q);
		end
	end

endmodule

@@ src/cursor_text_buffer_editor_top.sv @@
// Top level of the cursor text buffer editor: controller, datapath and port mapping.
//
// Edit requests enter on the s_ channel: s_tuser carries the opcode (insert, delete at
// cursor, move left, move right, read next) and s_tdata the character for an insert.
// Every request returns exactly one result on the m_ channel: m_tuser carries the
// status, m_tdata the character read and the buffer length, m_tlast marks that a
// read returned the final character and the read pointer went back to the head.
// The buffer is a doubly linked list in a 256-node pool held in three RAMs, with
// freed nodes kept on a stack in a fourth RAM.
// One request is worked at a time. Moves, deletes and refused requests go from the
// execute step straight to the final step; accepted inserts add a link step and reads
// of a non-empty buffer a fetch step, set by the registered RAM reads: an insert writes
// its links in two passes, a read fetches the successor link and then the character.
// The next request is taken in the idle state that follows the load of the result.
// A result that is not taken waits in the output register; the next request is
// still accepted and worked, and only its final load waits for the register.
// Reset empties the buffer and places cursor and read pointer on the head.
module cursor_text_buffer_editor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] char_out, [15:8] length
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	cte_pkg::cmd_t cmd;
	cte_pkg::sts_t sts;

	cte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	cte_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_opcode  (s_tuser),
		.in_char    (s_tdata),
		.out_status (m_tuser),
		.out_char   (m_tdata[7:0]),
		.out_last   (m_tlast),
		.out_length (m_tdata[15:8])
	);

`ifndef SYNTHESIS
	// One request at a time: an accepted request closes the input until it is done.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another was in progress");

	// A final character is only flagged by a completed read.
	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == cte_pkg::ST_DONE))
		else $error("last character flagged on a result that is not a completed read");

	// A read on an empty buffer reports zero length and no character.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == cte_pkg::ST_EMPTY)) |-> (m_tdata == 16'd0))
		else $error("empty status with nonzero length or character");

	// A refused insert only happens with the pool full.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == cte_pkg::ST_FULL)) |-> (m_tdata[15:8] == 8'd255))
		else $error("pool full reported below capacity");
`endif

endmodule
